### hw/rtl/prid_pkg.sv
// Package for the pairwise residue identity distance core.
// Holds the payload structs, the state enum, controller/datapath handshake structs and constants.
// No dependencies.
package prid_pkg;

  // Residue that is always blank
  localparam logic [7:0]  GapChar    = 8'h2D;
  localparam logic [7:0]  IndetReset = 8'd88;

  // Counters saturate at 65536
  localparam logic [16:0] CountLimit = 17'd65536;
  localparam logic [16:0] OneQ16     = 17'd65536;

  // One integer quotient bit plus sixteen fraction bits
  localparam logic [4:0]  DivSteps   = 5'd17;

  localparam int unsigned AddrW      = 3;
  localparam logic        RegIndet   = 1'b0;

  typedef struct packed {
    logic [7:0] residue_a;
    logic [7:0] residue_b;
    logic       last_column;
  } prid_in_t;

  typedef struct packed {
    logic [16:0] distance;
    logic [16:0] match_total;
    logic [16:0] compared_total;
    logic        no_compared;
  } prid_out_t;

  typedef enum logic [0:0] {
    ST_COUNT,
    ST_DIVIDE
  } prid_state_t;

  typedef struct packed {
    logic cnt_en;
    logic snap;
    logic div_step;
    logic out_load;
  } prid_cmd_t;

  typedef struct packed {
    logic div_done;
  } prid_status_t;

endpackage

### hw/rtl/prid_ctrl.sv
// Controller for the pairwise residue identity distance core.
// Sequences column counting, the serial divide and the output register.
// Depends on prid_pkg.
module prid_ctrl import prid_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  prid_status_t status,
  output prid_cmd_t    cmd
);

  prid_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_free      = !out_valid_r || !out_stall;
    // Non-last columns keep streaming during a divide; hold off the next last one
    in_stall      = (state_r == ST_DIVIDE) && in_last;
    accept        = in_valid && !in_stall;
    cmd           = '0;
    cmd.cnt_en    = accept;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_COUNT: begin
        if (accept && in_last) begin
          cmd.snap  = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_COUNT;
        end
      end
      default: state_nxt = ST_COUNT;
    endcase
  end

  assign out_valid = out_valid_r;

  a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && !status.div_done) |=> (state_r == ST_DIVIDE))
    else $error("divide left before all quotient bits were produced");

  a_snap_enters_divide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |=> (state_r == ST_DIVIDE && !status.div_done))
    else $error("last column did not start a divide");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten before transfer");

endmodule

### hw/rtl/prid_dp.sv
// Datapath for the pairwise residue identity distance core.
// Column counters, indeterminate-symbol register, restoring divider, result register.
// Depends on prid_pkg.
module prid_dp import prid_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  prid_in_t           in_data,
  input  prid_cmd_t          cmd,
  output prid_status_t       status,
  output prid_out_t          out_data,
  input  logic               cfg_wr,
  input  logic               cfg_sel,
  input  logic [7:0]         cfg_wdata,
  output logic [7:0]         indet
);

  logic [7:0]  indet_r;
  logic [16:0] match_cnt_r, match_cnt_nxt;
  logic [16:0] cmp_cnt_r, cmp_cnt_nxt;
  logic [16:0] rem_r, den_r, quo_r, hold_m_r;
  logic [4:0]  steps_r;
  prid_out_t   out_r;

  logic        blank_a, blank_b, both_blank, cmp_full, is_match;
  logic [16:0] cmp_inc, match_inc, cmp_upd, match_upd;
  logic        ge;
  logic [16:0] diff, rem_sel;

  always_comb begin
    blank_a    = (in_data.residue_a == GapChar) || (in_data.residue_a == indet_r);
    blank_b    = (in_data.residue_b == GapChar) || (in_data.residue_b == indet_r);
    both_blank = blank_a && blank_b;
    cmp_full   = cmp_cnt_r >= CountLimit;
    cmp_inc    = cmp_full ? CountLimit : cmp_cnt_r + 17'd1;
    match_inc  = (match_cnt_r >= CountLimit) ? CountLimit : match_cnt_r + 17'd1;
    // Keep matches no larger than compared columns under saturation
    is_match   = !blank_a && !blank_b && (in_data.residue_a == in_data.residue_b) &&
                 !(cmp_full && (match_cnt_r >= cmp_inc));
    cmp_upd    = both_blank ? cmp_cnt_r : cmp_inc;
    match_upd  = (!both_blank && is_match) ? match_inc : match_cnt_r;

    match_cnt_nxt = match_cnt_r;
    cmp_cnt_nxt   = cmp_cnt_r;
    if (cmd.cnt_en) begin
      if (in_data.last_column) begin
        match_cnt_nxt = '0;
        cmp_cnt_nxt   = '0;
      end else begin
        match_cnt_nxt = match_upd;
        cmp_cnt_nxt   = cmp_upd;
      end
    end

    ge      = rem_r >= den_r;
    diff    = rem_r - den_r;
    rem_sel = ge ? diff : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indet_r     <= IndetReset;
      match_cnt_r <= '0;
      cmp_cnt_r   <= '0;
      steps_r     <= '0;
    end else begin
      if (cfg_wr && (cfg_sel == RegIndet)) begin
        indet_r <= cfg_wdata;
      end
      match_cnt_r <= match_cnt_nxt;
      cmp_cnt_r   <= cmp_cnt_nxt;
      if (cmd.snap) begin
        steps_r <= DivSteps;
      end else if (cmd.div_step) begin
        steps_r <= steps_r - 5'd1;
      end
    end
  end

  // Restoring divide of match/compared, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      rem_r    <= match_upd;
      den_r    <= cmp_upd;
      hold_m_r <= match_upd;
      quo_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sel[15:0], 1'b0};
      quo_r <= {quo_r[15:0], ge};
    end
    if (cmd.out_load) begin
      out_r.distance       <= (den_r == '0) ? '0 : OneQ16 - quo_r;
      out_r.match_total    <= hold_m_r;
      out_r.compared_total <= den_r;
      out_r.no_compared    <= (den_r == '0);
    end
  end

  assign status.div_done = (steps_r == '0);
  assign out_data        = out_r;
  assign indet           = indet_r;

  a_match_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    match_cnt_r <= cmp_cnt_r)
    else $error("match count exceeds compared count");

  a_counters_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_en && in_data.last_column) |=> (match_cnt_r == '0 && cmp_cnt_r == '0))
    else $error("counters not cleared after last column");

  a_steps_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |=> (steps_r == DivSteps))
    else $error("divide step count not loaded");

endmodule

### hw/rtl/pairwise_residue_identity_distance_core.sv
// Top level of the pairwise residue identity distance core.
// Joins the controller and datapath and decodes the register port.
// Depends on prid_pkg, prid_ctrl and prid_dp.

// Residue columns of an aligned pair are taken at one per cycle. A column
// whose residues are both blank ('-' or the programmed indeterminate symbol)
// is skipped; otherwise it counts as compared, and as a match when both are
// non-blank and equal. Both counters saturate at 65536. The column marked
// last closes the pair: a restoring divider then forms the quotient one bit
// per cycle, so the result (distance = 65536 - floor(65536*match/compared),
// both counts, and no_compared when nothing was compared) goes to an output
// register once the divide is done and that register is free, and is held
// there until transferred. Columns of the next pair keep streaming during
// the divide; only its last column waits until that result is loaded. The
// indeterminate symbol sits at byte address 0 and resets to 'X'; the user
// must write it only while the core is idle, which the core does not enforce.
module pairwise_residue_identity_distance_core import prid_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  prid_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output prid_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  prid_cmd_t    cmd;
  prid_status_t status;
  logic         cfg_wr;
  logic [7:0]   indet;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegIndet) ? {24'd0, indet} : 32'd0;

  prid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_column),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  prid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .cfg_wr    (cfg_wr),
    .cfg_sel   (paddr[2]),
    .cfg_wdata (pwdata[7:0]),
    .indet     (indet)
  );

endmodule
